>>> rtl/lsbb64_pkg.sv
// Shared types, constants and the base64 alphabet lookup for the stego extractor.
package lsbb64_pkg;

  localparam int unsigned PosWidth    = 40;
  localparam int unsigned OffsetWidth = 24;
  localparam int unsigned CountWidth  = 32;
  localparam int unsigned RemWidth    = 31;

  localparam logic [PosWidth-1:0]    PosMax      = '1;
  localparam logic [OffsetWidth-1:0] OffsetReset = 24'd54;
  localparam logic [7:0]             CountBits   = 8'd32;
  localparam logic [7:0]             PadChar     = 8'h3D;  // '='
  localparam logic signed [4:0]      PendReset   = -5'sd8;
  localparam logic signed [4:0]      PendStep    = 5'sd6;
  localparam logic signed [4:0]      PendByte    = 5'sd8;

  typedef enum logic [1:0] {
    PhSkip,
    PhCount,
    PhChars,
    PhDone
  } phase_e;

  // One step result handed from the core to the output register.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       valid;
    logic       eom;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
  } b64_t;

  // Alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic b64_t b64_lookup(input logic [7:0] c);
    b64_t r;
    r.hit = 1'b1;
    r.idx = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.idx = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.idx = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.idx = 6'(c + 8'h04);
    end else if (c == 8'h2B) begin
      r.idx = 6'd62;
    end else if (c == 8'h2F) begin
      r.idx = 6'd63;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/lsbb64_core.sv
// Extraction state and one-step decode: position, count, character and base64 bit packing.
module lsbb64_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [7:0]                      file_byte_i,
  input  logic                            sof_i,
  input  logic [lsbb64_pkg::OffsetWidth-1:0] pixel_offset_i,
  output lsbb64_pkg::res_t                res_o
);
  import lsbb64_pkg::*;

  phase_e                 ph_q, ph_d;
  logic [PosWidth-1:0]    pos_q, pos_d;
  logic [CountWidth-1:0]  cnt_q, cnt_d;
  logic [RemWidth-1:0]    rem_q, rem_d;
  logic [7:0]             sh_q, sh_d;
  logic [2:0]             bic_q, bic_d;
  logic [11:0]            acc_q, acc_d;
  logic signed [4:0]      pend_q, pend_d;

  always_comb begin
    phase_e            ph;
    logic [PosWidth-1:0] pos;
    logic              lsb;
    logic signed [4:0] pend_t;
    b64_t              lk;

    res_o = '0;
    lsb   = file_byte_i[0];
    lk    = '0;
    pend_t = '0;

    // A start of file clears everything before this byte is looked at.
    if (sof_i) begin
      ph     = PhSkip;
      pos    = '0;
      cnt_d  = '0;
      rem_d  = '0;
      sh_d   = '0;
      bic_d  = '0;
      acc_d  = '0;
      pend_d = PendReset;
    end else begin
      ph     = ph_q;
      pos    = pos_q;
      cnt_d  = cnt_q;
      rem_d  = rem_q;
      sh_d   = sh_q;
      bic_d  = bic_q;
      acc_d  = acc_q;
      pend_d = pend_q;
    end

    pos_d = (pos != PosMax) ? pos + PosWidth'(1) : pos;

    if (ph == PhSkip && pos >= {{(PosWidth-OffsetWidth){1'b0}}, pixel_offset_i}) begin
      ph = PhCount;
    end
    ph_d = ph;

    unique case (ph)
      PhCount: begin
        cnt_d = {cnt_d[CountWidth-2:0], lsb};
        sh_d  = sh_d + 8'd1;
        if (sh_d >= CountBits) begin
          sh_d = '0;
          if (cnt_d[CountWidth-1] || cnt_d == '0) begin
            ph_d       = PhDone;
            res_o.emit = 1'b1;
            res_o.eom  = 1'b1;
          end else begin
            rem_d = cnt_d[RemWidth-1:0];
            bic_d = '0;
            ph_d  = PhChars;
          end
        end
      end
      PhChars: begin
        sh_d  = {sh_d[6:0], lsb};
        bic_d = bic_d + 3'd1;
        if (bic_d == '0) begin
          lk    = b64_lookup(sh_d);
          rem_d = rem_d - RemWidth'(1);
          if (!lk.hit) begin
            if (sh_d == PadChar) begin
              ph_d       = PhDone;
              res_o.emit = 1'b1;
              res_o.eom  = 1'b1;
            end
          end else begin
            acc_d  = {acc_d[5:0], lk.idx};
            pend_t = pend_d + PendStep;
            if (!pend_t[4]) begin
              // Balance is 0, 2 or 4 here.
              priority if (pend_t[2]) begin
                res_o.data = acc_d[11:4];
              end else if (pend_t[1]) begin
                res_o.data = acc_d[9:2];
              end else begin
                res_o.data = acc_d[7:0];
              end
              res_o.valid = 1'b1;
              res_o.emit  = 1'b1;
              pend_d      = pend_t - PendByte;
            end else begin
              pend_d = pend_t;
            end
          end
          sh_d = '0;
          if (ph_d == PhChars && rem_d == '0) begin
            ph_d       = PhDone;
            res_o.emit = 1'b1;
            res_o.eom  = 1'b1;
          end
        end
      end
      default: ;  // still skipping, or done until the next file
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhSkip;
      pos_q  <= '0;
      cnt_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
      bic_q  <= '0;
      acc_q  <= '0;
      pend_q <= PendReset;
    end else if (step_i) begin
      ph_q   <= ph_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      sh_q   <= sh_d;
      bic_q  <= bic_d;
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

endmodule

>>> rtl/lsb_stego_base64_extractor_unit.sv
// Top level: stream wrapper around the LSB stego extractor and base64 decoder.
//
//  channel   | dir | fields (low bit up)                      | handshake
//  ----------+-----+------------------------------------------+-------------------
//  s_axis    | in  | tdata: file_byte[7:0]; tuser: start_of_file | tvalid/tready
//  m_axis    | out | tdata: decoded_byte[7:0]; tuser: byte_valid;| tvalid/tready
//            |     | tlast: end_of_message                    |
//  cfg       | in  | cfg_wdata_i: pixel_offset[23:0]          | cfg_we_i, no wait
//
// One item per cycle sustained while the output is not stalled. An item is
// first held in the input register, then the core updates its state and,
// when the item produces a result, loads the output register.
// Reset (rst_ni low, asynchronous) empties both registers, returns the offset
// to 54 and the decoder to its header-skipping state.
// A stalled output holds the input register; s_axis_tready stays high whenever
// the output register is empty or being drained.
module lsb_stego_base64_extractor_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] file_byte
  input  logic                               s_axis_tuser,   // [0] start_of_file
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,   // [7:0] decoded_byte
  output logic                               m_axis_tuser,   // [0] byte_valid
  output logic                               m_axis_tlast,   // end_of_message
  input  logic                               cfg_we_i,
  input  logic [lsbb64_pkg::OffsetWidth-1:0] cfg_wdata_i     // pixel_offset
);
  import lsbb64_pkg::*;

  logic [OffsetWidth-1:0] offset_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_sof_q;

  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_bv_q;
  logic       out_eom_q;

  logic       s_accept;
  logic       advance;  // input register item may move through the core
  logic       step;
  res_t       res;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
      in_sof_q  <= s_axis_tuser;
    end
  end

  lsbb64_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .file_byte_i    (in_byte_q),
    .sof_i          (in_sof_q),
    .pixel_offset_i (offset_q),
    .res_o          (res)
  );

  // Result register; most items produce nothing and just pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      out_data_q <= res.data;
      out_bv_q   <= res.valid;
      out_eom_q  <= res.eom;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_bv_q;
  assign m_axis_tlast  = out_eom_q;

endmodule

>>> rtl/lsbb64_chk.sv
// Port-level checker for the stego extractor, bound to the top level.
module lsbb64_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A result held under backpressure keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // A result without a byte only ever marks the end, with zero data.
  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("result without byte is not an end mark");

  // A draining output never blocks the input side.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // A fresh result comes from the item taken at the edge before it appeared.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result appeared without a matching input item");

endmodule

bind lsb_stego_base64_extractor_unit lsbb64_chk u_lsbb64_chk (.*);

>>> tb/lsbb64_checker.sv
// Scoreboard for the stego extractor: tracks decoder state from accepted bytes, checks results.
module lsbb64_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] file_byte
  input  logic                               s_axis_tuser,   // [0] start_of_file
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [7:0]                         m_axis_tdata,   // [7:0] decoded_byte
  input  logic                               m_axis_tuser,   // [0] byte_valid
  input  logic                               m_axis_tlast,   // end_of_message
  input  logic                               cfg_we_i,
  input  logic [lsbb64_pkg::OffsetWidth-1:0] cfg_wdata_i,    // pixel_offset
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsbb64_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eom;
  } decoded_t;

  localparam logic [8*64-1:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [OffsetWidth-1:0] offset;
  logic [PosWidth-1:0]    pos;
  logic [CountWidth-1:0]  count;
  logic [RemWidth-1:0]    chars_left;
  int                     count_bits;
  logic [7:0]             char_bits;
  logic [2:0]             bit_idx;
  logic [11:0]            acc;
  int                     balance;
  phase_e                 phase;
  decoded_t               decoded_q[$];
  int                     fails;
  int                     seen;

  function automatic int sextet(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (Alphabet[8*(63-i) +: 8] == c) return i;
    end
    return -1;
  endfunction

  task automatic restart_file();
    pos        = '0;
    count      = '0;
    chars_left = '0;
    count_bits = 0;
    char_bits  = '0;
    bit_idx    = '0;
    acc        = '0;
    balance    = -8;
    phase      = PhSkip;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // One accepted file byte: advance the decoder copy, queue a result if one is due.
  task automatic track_file_byte(input logic [7:0] fb, input logic sof);
    logic [PosWidth-1:0] here;
    logic [7:0]          c;
    int                  v;
    decoded_t            res;
    logic                emit;
    res  = '0;
    emit = 1'b0;
    if (sof) restart_file();
    here = pos;
    if (pos != PosMax) pos = pos + PosWidth'(1);
    if (phase == PhSkip && here >= offset) phase = PhCount;
    case (phase)
      PhCount: begin
        count = {count[CountWidth-2:0], fb[0]};
        count_bits++;
        if (count_bits >= CountBits) begin
          count_bits = 0;
          if (count[CountWidth-1] || count == '0) begin
            phase   = PhDone;
            res.eom = 1'b1;
            emit    = 1'b1;
          end else begin
            chars_left = count[RemWidth-1:0];
            bit_idx    = '0;
            phase      = PhChars;
          end
        end
      end
      PhChars: begin
        char_bits = {char_bits[6:0], fb[0]};
        bit_idx   = bit_idx + 3'd1;
        if (bit_idx == '0) begin
          c          = char_bits;
          char_bits  = '0;
          chars_left = chars_left - RemWidth'(1);
          v          = sextet(c);
          if (v < 0) begin
            if (c == PadChar) begin
              phase   = PhDone;
              res.eom = 1'b1;
              emit    = 1'b1;
            end
          end else begin
            acc     = {acc[5:0], 6'(v)};
            balance = balance + 6;
            if (balance >= 0) begin
              res.data  = 8'(acc >> balance);
              res.valid = 1'b1;
              emit      = 1'b1;
              balance   = balance - 8;
            end
          end
          if (phase == PhChars && chars_left == '0) begin
            phase   = PhDone;
            res.eom = 1'b1;
            emit    = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (emit) decoded_q = {decoded_q, res};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    if (!rst_ni) begin
      offset = OffsetReset;
      restart_file();
      decoded_q.delete();
    end else begin
      if (cfg_we_i) offset = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        seen++;
        if (decoded_q.size() == 0) begin
          $error("unexpected result: decoded_byte %0d byte_valid %0d end_of_message %0d",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          check_field("decoded_byte", want.data, m_axis_tdata);
          check_field("byte_valid", want.valid, m_axis_tuser);
          check_field("end_of_message", want.eom, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) track_file_byte(s_axis_tdata, s_axis_tuser);
    end
    fail_count_o <= fails;
    pending_o    <= decoded_q.size();
    results_o    <= seen;
  end

endmodule

>>> tb/testbench.sv
// Stego extractor test: builds hidden-message files in pixel LSBs, streams them in, scores output.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lsbb64_pkg::*;

  localparam int HoldCycles  = 300;   // long output back-pressure stretch
  localparam int DrainCycles = 4;     // covers the pipe plus margin for result-less items
  localparam int IdleLimit   = 3000;  // cycles with no handshake before giving up

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;  // [7:0] file_byte
  logic                   s_axis_tuser  = 1'b0; // [0] start_of_file
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;        // [7:0] decoded_byte
  logic                   m_axis_tuser;        // [0] byte_valid
  logic                   m_axis_tlast;        // end_of_message
  logic                   cfg_we_i      = 1'b0;
  logic [OffsetWidth-1:0] cfg_wdata_i   = '0;  // pixel_offset

  int          fail_count;
  int          pending;
  int          results;

  int          src_idle_pct = 18;
  int          rx_idle_pct  = 51;
  int          hold_ticket  = 0;   // bumped by stimulus to request a hold-off
  int          hold_seen    = 0;
  int          hold_left    = 0;
  logic        sof_pending  = 1'b0; // next item carries start_of_file
  int          live_items   = 0;    // items past the header, i.e. ones the decoder consumes
  int unsigned offset_now   = OffsetReset;
  logic [7:0]  msg_q[$];            // base64 text of the next hidden message

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lsb_stego_base64_extractor_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .cfg_we_i,
    .cfg_wdata_i
  );

  lsbb64_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .cfg_we_i,
    .cfg_wdata_i,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  // Sink: random ready, or a counted hold-off when the stimulus asks for one.
  always @(posedge clk_i) begin
    if (hold_ticket != hold_seen) begin
      hold_seen     <= hold_ticket;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: any handshake on either side resets the quiet counter.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // One item on s_axis. tvalid is only dropped during a random gap, so
  // back-to-back items never see a low/high pair in one time step.
  task automatic put_item(input logic [7:0] fb, input bit live);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= fb;
    s_axis_tuser  <= sof_pending;
    sof_pending    = 1'b0;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (live) live_items++;
  endtask

  // Hide the low n bits of value, MSB first, in the LSBs of random bytes.
  task automatic put_lsb_bits(input logic [31:0] value, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      put_item({7'($urandom), value[i]}, 1'b1);
    end
  endtask

  // Count word, queued text, then tail bytes (ignored once the message is done).
  task automatic send_body(input logic [31:0] count, input int unsigned tail);
    put_lsb_bits(count, 32);
    while (msg_q.size() != 0) put_lsb_bits({24'd0, msg_q.pop_front()}, 8);
    repeat (tail) put_item(8'($urandom), 1'b0);
  endtask

  // A whole file: start mark, header bytes up to the pixel offset, message.
  task automatic send_file(input logic [31:0] count, input int unsigned tail);
    sof_pending = 1'b1;
    repeat (offset_now) put_item(8'($urandom), 1'b0);
    send_body(count, tail);
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_q = {msg_q, s[i]};
  endtask

  // Sender pause: drop tvalid, wait out every expected result plus the pipe.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_offset(input logic [OffsetWidth-1:0] value);
    settle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    offset_now   = value;
  endtask

  function automatic logic [7:0] b64_char(input int unsigned idx);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    if (idx == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  // Mostly alphabet chars; a few pads and arbitrary (often invalid) bytes.
  function automatic logic [7:0] random_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) return PadChar;
    if (pick < 11) return 8'($urandom);
    return b64_char($urandom_range(63));
  endfunction

  task automatic run_phase(input int src_pct, input int rx_pct, input int target,
                           input bit do_hold);
    int          stop;
    int unsigned n;
    int unsigned pick;
    logic [31:0] count;
    bit          held;
    src_idle_pct = src_pct;
    rx_idle_pct  = rx_pct;
    stop         = live_items + target;
    held         = 1'b0;
    while (live_items < stop) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        set_offset(($urandom_range(9) == 0) ? OffsetReset : OffsetWidth'($urandom_range(12)));
      end else if (pick < 14) begin
        // stray bytes, now and then a start-of-file in the middle of things
        repeat ($urandom_range(1, 12)) begin
          sof_pending = ($urandom_range(7) == 0);
          put_item(8'($urandom), 1'b1);
        end
      end else if (pick < 22) begin
        // truncated message: count promises more chars than arrive
        n = $urandom_range(0, 6);
        if ($urandom_range(3) == 0) begin
          count = {1'b0, 31'($urandom)} | 32'd64;
        end else begin
          count = 32'(n + $urandom_range(1, 8));
        end
        repeat (n) msg_q = {msg_q, random_char()};
        send_file(count, 0);
      end else begin
        // message with random text whose count matches it, or a zero or negative count
        n = $urandom_range(1, 12);
        case ($urandom_range(19))
          0:       count = '0;
          1:       count = {1'b1, 31'($urandom)};
          default: count = 32'(n);
        endcase
        if (count == 32'(n)) begin
          repeat (n) msg_q = {msg_q, random_char()};
        end
        send_file(count, $urandom_range(3));
      end
      // halfway through: stall the sink long enough to back up the input
      if (do_hold && !held && live_items >= stop - target / 2) begin
        hold_ticket <= hold_ticket + 1;
        held         = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset offset of 54 left in place for the first file
    load_text("TWFu");
    send_file(32'd4, 2);
    set_offset('0);
    load_text("+/+/");
    send_file(32'd4, 0);
    // zero and negative counts end at once
    send_file(32'd0, 2);
    send_file(32'h8000_0000, 0);
    send_file(32'hFFFF_FFFF, 1);
    // pad stops decoding; rest of the file is ignored
    load_text("QQ==");
    send_file(32'd8, 3);
    // invalid char last, then invalid char in the middle
    load_text("TW!");
    send_file(32'd3, 0);
    load_text("T!WFu");
    send_file(32'd5, 0);
    // long count cut short by the next start-of-file
    load_text("TWF");
    send_file(32'd40, 0);
    set_offset(24'd3);
    load_text("YQ");
    send_file(32'd2, 1);
    // max offset, then lowered mid-stream: header ends at the next byte
    set_offset('1);
    sof_pending = 1'b1;
    repeat (20) put_item(8'($urandom), 1'b0);
    set_offset(24'd10);
    load_text("YQ");
    send_body(32'd2, 0);

    run_phase(18, 51, 70, 1'b1);
    run_phase(51, 18, 60, 1'b0);
    run_phase(0, 0, 60, 1'b0);
    settle();

    $display("Covered %0d decoder items over offsets 0, 3, 10, 54, max and small randoms,",
             live_items);
    $display("with %0d results checked: zero/negative counts, pads, bad chars, cut messages.",
             results);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
